// File: rtl/core/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// shared types and constants of the barometric sensor compensation pipeline
// ----------------------------------------------------------------------------
package bsc_pkg;

    localparam int DIV_STEPS = 32;
    localparam int SIDE_W    = 64;

    localparam logic [1:0] CFG_CAL_A = 2'd0;
    localparam logic [1:0] CFG_CAL_B = 2'd1;
    localparam logic [1:0] CFG_CAL_C = 2'd2;

    localparam logic signed [31:0] B6_OFFSET   = 32'sd4000;
    localparam logic [31:0]        X3_OFFSET   = 32'd32768;
    localparam logic [31:0]        B7_SCALE    = 32'd50000;
    localparam logic signed [31:0] P_COEF_SQ   = 32'sd3038;
    localparam logic signed [31:0] P_COEF_LIN  = -32'sd7357;
    localparam logic signed [31:0] P_OFFSET    = 32'sd3791;
    localparam logic signed [31:0] TEMP_ROUND  = 32'sd8;
    localparam logic signed [31:0] TEMP_MAX    = 32'sd32767;
    localparam logic signed [31:0] TEMP_MIN    = -32'sd32768;
    localparam logic signed [31:0] PRES_MAX    = 32'sd262143;

    // one divider cell: partial remainder, dividend/quotient shifter, divisor
    typedef struct packed {
        logic              valid;
        logic [31:0]       rem;
        logic [31:0]       dvd;
        logic [31:0]       dvs;
        logic [SIDE_W-1:0] side;
    } div_stage_t;

    // payload that rides along the temperature divider
    typedef struct packed {
        logic        err;
        logic        neg;
        logic [16:0] x1;
        logic [15:0] up;
    } tdiv_side_t;

    // payload that rides along the pressure divider
    typedef struct packed {
        logic        err;
        logic        hi;
        logic [15:0] temp;
    } pdiv_side_t;

endpackage

// File: rtl/core/bsc_in_if.sv
// ----------------------------------------------------------------------------
// bsc_in_if
// raw sample channel: valid/ready with temperature and pressure readings
// ----------------------------------------------------------------------------
interface bsc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] raw_temperature;
    logic [15:0] raw_pressure;

    modport source (output valid, output raw_temperature, output raw_pressure,
                    input ready);
    modport sink   (input valid, input raw_temperature, input raw_pressure,
                    output ready);
endinterface

// File: rtl/core/bsc_out_if.sv
// ----------------------------------------------------------------------------
// bsc_out_if
// compensated result channel: valid/ready with temperature and pressure
// ----------------------------------------------------------------------------
interface bsc_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] temperature_tenths;
    logic [17:0]        pressure_pa;
    logic               divide_error;

    modport source (output valid, output temperature_tenths, output pressure_pa,
                    output divide_error, input ready);
    modport sink   (input valid, input temperature_tenths, input pressure_pa,
                    input divide_error, output ready);
endinterface

// File: rtl/core/barometric_sensor_compensation_top.sv
// ----------------------------------------------------------------------------
// barometric_sensor_compensation_top
// integer temperature and pressure compensation, oversampling setting 0
// ----------------------------------------------------------------------------
// usage:
//   sample channel takes one raw temperature and one raw pressure reading per
//   transaction; result channel returns temperature in 0.1 degC, pressure in
//   Pa and a divide error flag, one result transaction per sample
//   calibration words are written over cfg_we/cfg_index/cfg_data while idle
// throughput: one sample per cycle; the pipeline is fully stalled as one
//   whole while a result waits on result.ready
// path: from sample transaction to result valid, a sample passes the two
//   32-cell division chains (one quotient bit per cell) and the
//   9 register stages around them
// reset: rst_n clears all valid flags and the calibration words to zero;
//   no clearing pass, sample.ready is high right out of reset
// stall: when result.ready is low with a result held, sample.ready drops and
//   every stage holds its contents; nothing is lost or repeated
// ----------------------------------------------------------------------------
module barometric_sensor_compensation_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    bsc_in_if.sink      sample,
    bsc_out_if.source   result
);

    logic [63:0] cal_a_reg;
    logic [63:0] cal_b_reg;
    logic [47:0] cal_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_a_reg <= '0;
            cal_b_reg <= '0;
            cal_c_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bsc_pkg::CFG_CAL_A: cal_a_reg <= cfg_data;
                bsc_pkg::CFG_CAL_B: cal_b_reg <= cfg_data;
                bsc_pkg::CFG_CAL_C: cal_c_reg <= cfg_data[47:0];
                default:            ;
            endcase
        end
    end

    // calibration coefficients, extended to 32 bits
    logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic [31:0]        ac4, ac5, ac6;

    assign ac1 = 32'(signed'(cal_a_reg[15:0]));
    assign ac2 = 32'(signed'(cal_a_reg[31:16]));
    assign ac3 = 32'(signed'(cal_a_reg[47:32]));
    assign ac4 = {16'd0, cal_a_reg[63:48]};
    assign ac5 = {16'd0, cal_b_reg[15:0]};
    assign ac6 = {16'd0, cal_b_reg[31:16]};
    assign b1  = 32'(signed'(cal_b_reg[47:32]));
    assign b2  = 32'(signed'(cal_b_reg[63:48]));
    assign mc  = 32'(signed'(cal_c_reg[31:16]));
    assign md  = 32'(signed'(cal_c_reg[47:32]));

    logic out_valid_reg;
    logic adv;

    assign adv          = !out_valid_reg || result.ready;
    assign sample.ready = adv;

    // stage 1: raw temperature product
    logic        s1_valid_reg;
    logic [31:0] s1_prod_reg;
    logic [15:0] s1_up_reg;
    logic [31:0] s1_prod_next;

    assign s1_prod_next = ({16'd0, sample.raw_temperature} - ac6) * ac5;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= sample.valid;
            s1_prod_reg  <= s1_prod_next;
            s1_up_reg    <= sample.raw_pressure;
        end
    end

    // temperature divider load: magnitudes and quotient sign
    logic signed [31:0]   t_x1, t_den, t_num;
    logic [31:0]          t_num_mag, t_den_mag;
    bsc_pkg::tdiv_side_t  t_side_in;
    bsc_pkg::div_stage_t  t_load;
    bsc_pkg::div_stage_t  t_done;

    always_comb
    begin
        t_x1      = $signed(s1_prod_reg) >>> 15;
        t_den     = t_x1 + md;
        t_num     = mc <<< 11;
        t_num_mag = t_num[31] ? 32'(-t_num) : t_num;
        t_den_mag = t_den[31] ? 32'(-t_den) : t_den;
        t_side_in.err = (t_den == 32'sd0);
        t_side_in.neg = t_num[31] ^ t_den[31];
        t_side_in.x1  = t_x1[16:0];
        t_side_in.up  = s1_up_reg;
        t_load.valid  = s1_valid_reg;
        t_load.rem    = '0;
        t_load.dvd    = t_num_mag;
        t_load.dvs    = t_den_mag;
        t_load.side   = bsc_pkg::SIDE_W'(t_side_in);
    end

    bsc_div_chain u_tdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .load  (t_load),
        .done  (t_done)
    );

    // stage p1: b5, saturated temperature, b6
    bsc_pkg::tdiv_side_t t_side_out;
    logic signed [31:0]  p1_x2, p1_b5, p1_tf, p1_b6_next;
    logic [15:0]         p1_temp_next;

    always_comb
    begin
        t_side_out = bsc_pkg::tdiv_side_t'(t_done.side[$bits(bsc_pkg::tdiv_side_t)-1:0]);
        p1_x2      = t_side_out.neg ? 32'(-t_done.dvd) : t_done.dvd;
        p1_b5      = 32'(signed'(t_side_out.x1)) + p1_x2;
        p1_tf      = (p1_b5 + bsc_pkg::TEMP_ROUND) >>> 4;
        p1_b6_next = p1_b5 - bsc_pkg::B6_OFFSET;
        if (p1_tf > bsc_pkg::TEMP_MAX)
            p1_temp_next = bsc_pkg::TEMP_MAX[15:0];
        else if (p1_tf < bsc_pkg::TEMP_MIN)
            p1_temp_next = bsc_pkg::TEMP_MIN[15:0];
        else
            p1_temp_next = p1_tf[15:0];
    end

    logic               p1_valid_reg, p1_err_reg;
    logic signed [31:0] p1_b6_reg;
    logic [15:0]        p1_temp_reg, p1_up_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_valid_reg <= t_done.valid;
            p1_err_reg   <= t_side_out.err;
            p1_b6_reg    <= p1_b6_next;
            p1_temp_reg  <= p1_temp_next;
            p1_up_reg    <= t_side_out.up;
        end
    end

    // stage p2: products of b6
    logic               p2_valid_reg, p2_err_reg;
    logic signed [31:0] p2_sqr_reg, p2_a2_reg, p2_a3_reg;
    logic [15:0]        p2_temp_reg, p2_up_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p2_valid_reg <= p1_valid_reg;
            p2_err_reg   <= p1_err_reg;
            p2_sqr_reg   <= p1_b6_reg * p1_b6_reg;
            p2_a2_reg    <= ac2 * p1_b6_reg;
            p2_a3_reg    <= ac3 * p1_b6_reg;
            p2_temp_reg  <= p1_temp_reg;
            p2_up_reg    <= p1_up_reg;
        end
    end

    // stage p3: b1, b2 products with the scaled square
    logic signed [31:0] p3_sq;
    logic               p3_valid_reg, p3_err_reg;
    logic signed [31:0] p3_x2a_reg, p3_x1b_reg, p3_b2sq_reg, p3_b1sq_reg;
    logic [15:0]        p3_temp_reg, p3_up_reg;

    assign p3_sq = p2_sqr_reg >>> 12;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p3_valid_reg <= p2_valid_reg;
            p3_err_reg   <= p2_err_reg;
            p3_x2a_reg   <= p2_a2_reg >>> 11;
            p3_x1b_reg   <= p2_a3_reg >>> 13;
            p3_b2sq_reg  <= b2 * p3_sq;
            p3_b1sq_reg  <= b1 * p3_sq;
            p3_temp_reg  <= p2_temp_reg;
            p3_up_reg    <= p2_up_reg;
        end
    end

    // stage p4: b3 and the b4 multiplicand
    logic signed [31:0] p4_x3, p4_s, p4_b3_next, p4_x3p;
    logic [31:0]        p4_t_next;

    always_comb
    begin
        p4_x3      = (p3_b2sq_reg >>> 11) + p3_x2a_reg;
        p4_s       = (ac1 <<< 2) + p4_x3 + 32'sd2;
        // divide by four rounding toward zero
        p4_b3_next = (p4_s + (p4_s[31] ? 32'sd3 : 32'sd0)) >>> 2;
        p4_x3p     = (p3_x1b_reg + (p3_b1sq_reg >>> 16) + 32'sd2) >>> 2;
        p4_t_next  = p4_x3p + bsc_pkg::X3_OFFSET;
    end

    logic               p4_valid_reg, p4_err_reg;
    logic signed [31:0] p4_b3_reg;
    logic [31:0]        p4_t_reg;
    logic [15:0]        p4_temp_reg, p4_up_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p4_valid_reg <= p3_valid_reg;
            p4_err_reg   <= p3_err_reg;
            p4_b3_reg    <= p4_b3_next;
            p4_t_reg     <= p4_t_next;
            p4_temp_reg  <= p3_temp_reg;
            p4_up_reg    <= p3_up_reg;
        end
    end

    // stage p5: b4 product and b7
    logic        p5_valid_reg, p5_err_reg;
    logic [31:0] p5_b4p_reg, p5_b7_reg;
    logic [15:0] p5_temp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p5_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p5_valid_reg <= p4_valid_reg;
            p5_err_reg   <= p4_err_reg;
            p5_b4p_reg   <= ac4 * p4_t_reg;
            p5_b7_reg    <= ({16'd0, p4_up_reg} - p4_b3_reg) * bsc_pkg::B7_SCALE;
            p5_temp_reg  <= p4_temp_reg;
        end
    end

    // pressure divider load: the doubling goes before or after the divide
    logic [31:0]          pd_b4;
    bsc_pkg::pdiv_side_t  p_side_in;
    bsc_pkg::div_stage_t  p_load;
    bsc_pkg::div_stage_t  p_done;

    always_comb
    begin
        pd_b4          = {15'd0, p5_b4p_reg[31:15]};
        p_side_in.err  = p5_err_reg || (pd_b4 == 32'd0);
        p_side_in.hi   = p5_b7_reg[31];
        p_side_in.temp = p5_temp_reg;
        p_load.valid   = p5_valid_reg;
        p_load.rem     = '0;
        p_load.dvd     = p5_b7_reg[31] ? p5_b7_reg : {p5_b7_reg[30:0], 1'b0};
        p_load.dvs     = pd_b4;
        p_load.side    = bsc_pkg::SIDE_W'(p_side_in);
    end

    bsc_div_chain u_pdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv),
        .load  (p_load),
        .done  (p_done)
    );

    // stage p7: squared and linear pressure terms
    bsc_pkg::pdiv_side_t p_side_out;
    logic signed [31:0]  p7_p, p7_a;

    always_comb
    begin
        p_side_out = bsc_pkg::pdiv_side_t'(p_done.side[$bits(bsc_pkg::pdiv_side_t)-1:0]);
        p7_p       = p_side_out.hi ? {p_done.dvd[30:0], 1'b0} : p_done.dvd;
        p7_a       = p7_p >>> 8;
    end

    logic               p7_valid_reg, p7_err_reg;
    logic signed [31:0] p7_p_reg, p7_sq_reg, p7_lin_reg;
    logic [15:0]        p7_temp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p7_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p7_valid_reg <= p_done.valid;
            p7_err_reg   <= p_side_out.err;
            p7_p_reg     <= p7_p;
            p7_sq_reg    <= p7_a * p7_a;
            p7_lin_reg   <= bsc_pkg::P_COEF_LIN * p7_p;
            p7_temp_reg  <= p_side_out.temp;
        end
    end

    // stage p8: scale the square term
    logic               p8_valid_reg, p8_err_reg;
    logic signed [31:0] p8_p_reg, p8_m1_reg, p8_x2_reg;
    logic [15:0]        p8_temp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p8_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p8_valid_reg <= p7_valid_reg;
            p8_err_reg   <= p7_err_reg;
            p8_p_reg     <= p7_p_reg;
            p8_m1_reg    <= p7_sq_reg * bsc_pkg::P_COEF_SQ;
            p8_x2_reg    <= p7_lin_reg >>> 16;
            p8_temp_reg  <= p7_temp_reg;
        end
    end

    // output stage: final pressure, saturation, error override
    logic signed [31:0] o_pres;
    logic [17:0]        o_pres_next;
    logic [15:0]        o_temp_next;

    always_comb
    begin
        o_pres = p8_p_reg + (((p8_m1_reg >>> 16) + p8_x2_reg + bsc_pkg::P_OFFSET) >>> 4);
        if (o_pres < 32'sd0)
            o_pres_next = '0;
        else if (o_pres > bsc_pkg::PRES_MAX)
            o_pres_next = bsc_pkg::PRES_MAX[17:0];
        else
            o_pres_next = o_pres[17:0];
        o_temp_next = p8_temp_reg;
        if (p8_err_reg)
        begin
            o_pres_next = '0;
            o_temp_next = '0;
        end
    end

    logic [15:0] out_temp_reg;
    logic [17:0] out_pres_reg;
    logic        out_err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= p8_valid_reg;
            out_temp_reg  <= o_temp_next;
            out_pres_reg  <= o_pres_next;
            out_err_reg   <= p8_err_reg;
        end
    end

    assign result.valid              = out_valid_reg;
    assign result.temperature_tenths = $signed(out_temp_reg);
    assign result.pressure_pa        = out_pres_reg;
    assign result.divide_error       = out_err_reg;

endmodule

// File: rtl/core/bsc_div_cell.sv
// ----------------------------------------------------------------------------
// bsc_div_cell
// one restoring division step: shifts in one dividend bit, emits one quotient bit
// ----------------------------------------------------------------------------
module bsc_div_cell (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  bsc_pkg::div_stage_t     prev,
    output bsc_pkg::div_stage_t     cur
);

    bsc_pkg::div_stage_t cell_reg;
    bsc_pkg::div_stage_t cell_next;
    logic [32:0]         trial;
    logic [32:0]         diff;
    logic                ge;

    always_comb
    begin
        trial = {prev.rem, prev.dvd[31]};
        diff  = trial - {1'b0, prev.dvs};
        ge    = (trial >= {1'b0, prev.dvs});
        cell_next       = prev;
        cell_next.rem   = ge ? diff[31:0] : trial[31:0];
        cell_next.dvd   = {prev.dvd[30:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign cur = cell_reg;

endmodule

// File: rtl/core/bsc_div_chain.sv
// ----------------------------------------------------------------------------
// bsc_div_chain
// row of division cells, one quotient bit per cell, unsigned 32 by 32
// ----------------------------------------------------------------------------
module bsc_div_chain (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  bsc_pkg::div_stage_t     load,
    output bsc_pkg::div_stage_t     done
);

    bsc_pkg::div_stage_t link [bsc_pkg::DIV_STEPS+1];

    assign link[0] = load;

    for (genvar i = 0; i < bsc_pkg::DIV_STEPS; i++)
    begin : g_cell
        bsc_div_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .prev  (link[i]),
            .cur   (link[i+1])
        );
    end

    // after the last cell the dividend shifter holds the quotient
    assign done = link[bsc_pkg::DIV_STEPS];

endmodule
